// ===== src/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-character function of the Base64 encoder.
`default_nettype none

package b64e_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned SextW = 6;

  localparam logic [CharW-1:0] PadChar = 7'h3D;
  localparam logic [1:0] LastCharIdx = 2'd3;

  // One complete or final group as handed from the front to the back.
  typedef struct packed {
    logic [3*ByteW-1:0] bits;     // first byte in the top bits, missing bytes are zero
    logic [1:0]         n_bytes;  // 1 to 3 bytes carry data
    logic               last;
  } b64e_group_t;

  function automatic logic [CharW-1:0] b64e_char(input logic [SextW-1:0] s);
    logic [CharW-1:0] v;
    logic [CharW-1:0] c;
    v = {1'b0, s};
    if (v < 7'd26) begin
      c = 7'h41 + v;
    end else if (v < 7'd52) begin
      c = 7'h61 + (v - 7'd26);
    end else if (v < 7'd62) begin
      c = 7'h30 + (v - 7'd52);
    end else if (v == 7'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/b64e_fifo.sv =====
// Short register queue of byte groups between the front and the back of the encoder.
`default_nettype none

module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire b64e_group_t wr_data_i,
  output logic             full_o,
  input  wire logic        rd_en_i,
  output b64e_group_t      rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  b64e_group_t           mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_wr, do_rd;

  assign full_o    = (count_q == DepthCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("queue count above depth");

  // A write request on a full queue is dropped, so the count cannot grow then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !rd_en_i) |=> (count_q == DepthCnt))
    else $error("queue overrun");

endmodule

`default_nettype wire

// ===== src/b64e_front.sv =====
// Front of the encoder: gathers input bytes into groups of up to three.
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  grp_valid_o,
  output b64e_group_t           grp_o,
  input  wire logic             grp_full_i
);

  logic [ByteW-1:0] held_q [2];
  logic [1:0]       held_count_q, held_count_d;
  logic             accept, complete, two_held;
  logic [ByteW-1:0] g0, g1, g2;

  assign full     = grp_full_i;
  assign accept   = push && !grp_full_i;
  // A count of three cannot occur; it behaves like two.
  assign two_held = held_count_q[1];
  assign complete = accept && (last_byte_i || two_held);

  always_comb begin
    g0 = (held_count_q != 2'd0) ? held_q[0] : data_byte_i;
    g1 = two_held ? held_q[1] : ((held_count_q == 2'd1) ? data_byte_i : '0);
    g2 = two_held ? data_byte_i : '0;
    grp_o.bits    = {g0, g1, g2};
    grp_o.n_bytes = two_held ? 2'd3 : held_count_q + 2'd1;
    grp_o.last    = last_byte_i;
  end

  assign grp_valid_o = complete;

  always_comb begin
    held_count_d = held_count_q;
    if (complete) begin
      held_count_d = '0;
    end else if (accept) begin
      held_count_d = held_count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
    end else begin
      held_count_q <= held_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !complete) begin
      held_q[held_count_q[0]] <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/b64e_back.sv =====
// Back of the encoder: turns each queued group into four output characters.
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire b64e_group_t grp_i,
  input  wire logic        grp_empty_i,
  output logic             grp_pop_o,
  output logic             empty,
  input  wire logic        pop,
  output logic [CharW-1:0] out_char_o,
  output logic             last_char_o
);

  b64e_group_t      cur_q;
  logic             busy_q, busy_d;
  logic [1:0]       idx_q, idx_d;
  logic             load, taken;
  logic [SextW-1:0] sext;

  assign taken     = pop && busy_q;
  assign load      = !grp_empty_i && (!busy_q || (taken && idx_q == LastCharIdx));
  assign grp_pop_o = load;
  assign empty     = !busy_q;

  always_comb begin
    case (idx_q)
      2'd0:    sext = cur_q.bits[23:18];
      2'd1:    sext = cur_q.bits[17:12];
      2'd2:    sext = cur_q.bits[11:6];
      default: sext = cur_q.bits[5:0];
    endcase
    // A group of n bytes carries n + 1 data characters; the rest are pads.
    out_char_o  = (idx_q <= cur_q.n_bytes) ? b64e_char(sext) : PadChar;
    last_char_o = cur_q.last && (idx_q == LastCharIdx);
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (taken) begin
      if (idx_q == LastCharIdx) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= grp_i;
    end
  end

  // While idle the character index rests at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> (idx_q == 2'd0))
    else $error("character index moved while idle");

  // A stalled character holds its position in the group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop) |=> (busy_q && $stable(idx_q)))
    else $error("character lost while stalled");

endmodule

`default_nettype wire

// ===== src/base64_encoder_core.sv =====
// Base64 encoder: gathers bytes into groups of three and emits four characters per group.
//
// Input channel: push / full with data_byte_i and last_byte_i; a word is taken at a
// clock edge where push is high and full is low. Output channel: empty / pop with
// out_char_o and last_char_o; the oldest character is shown while empty is low and is
// taken at an edge where pop is high and empty is low.
// Every three bytes, or a shorter final group, yield four characters, padded with '='
// when the group is short; last_char_o marks the final character of a message.
// The byte that closes a group completes it in the front; the group is written into the
// queue and then loaded into the back's serializer before its first character is shown.
// Throughput is one character per cycle while pop stays high; the serializer sets it.
// A queue of FifoDepth groups sits between the byte gatherer and the serializer, so
// bytes keep flowing while the receiver stalls until that queue fills; then full rises.
// Reset empties the queue, drops any partly gathered group and leaves the output empty.

`default_nettype none

module base64_encoder_core
  import b64e_pkg::*;
#(
  parameter int unsigned FifoDepth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [CharW-1:0]      out_char_o,
  output logic                  last_char_o
);

  b64e_group_t wr_grp, rd_grp;
  logic        wr_en, q_full, q_empty, rd_en;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .grp_valid_o (wr_en),
    .grp_o       (wr_grp),
    .grp_full_i  (q_full)
  );

  b64e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_grp),
    .full_o    (q_full),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_grp),
    .empty_o   (q_empty)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (rd_grp),
    .grp_empty_i (q_empty),
    .grp_pop_o   (rd_en),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire
